// ===== hdl/ssmhb_pkg.sv =====
// Package for the spectrum sweep max-hold binner.
// Types, codes and reset constants; no dependencies.
`timescale 1ns / 1ps
package ssmhb_pkg;

  localparam int NUM_BINS_DEF = 128;
  localparam int IDX_W        = 7;
  localparam int DIV_LW       = 17;
  localparam int CFG_IDX_W    = 3;

  localparam logic [15:0] LEVEL_LOW_RST  = 16'd30;
  localparam logic [15:0] LEVEL_HIGH_RST = 16'd200;
  localparam logic [15:0] MIN_SPAN_RST   = 16'd40;
  localparam logic [31:0] FREQ_STEP_RST  = 32'd2500;
  localparam logic [7:0]  DISP_H_RST     = 8'd44;
  localparam logic [16:0] MARGIN_PX      = 17'd2;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_BEGIN = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_START = 3'd0,
    REG_BAND_END   = 3'd1,
    REG_FREQ_STEP  = 3'd2,
    REG_MIN_SPAN   = 3'd3,
    REG_DISP_H     = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    DK_XC     = 2'd0,
    DK_XN     = 2'd1,
    DK_MARGIN = 2'd2
  } div_kind_e;

endpackage

// ===== hdl/ssmhb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ssmhb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hdl/spectrum_sweep_max_hold_binner.sv =====
// Top level of the spectrum sweep max-hold binner.
// Depends on ssmhb_pkg and ssmhb_ram.
//
//  channel   direction  handshake                 payload
//  command   in         start / busy              mode, frequency, levels, bin_index
//  result    out        done_o strobe, 1 cycle    bin fields, fill, auto level, peak
//  config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Steps: an add item maps its frequency, and the next one unless it ends the
// sweep, to bins through the shared restoring divider (a mapping that lands
// on an end of the band skips the divider), then does a RAM read and then a
// conditional write for each covered bin.
// A begin-sweep item scans the filled bins at one RAM read per cycle, then
// runs the divider for the floor margin; it skips both when fewer than two
// bins are filled.
// Clear and read-only items go straight to the readout of the requested bin.
// Reset clears every bin at once through per-bin valid flags; no clearing pass.
// The receiver cannot stall: the result is shown for one cycle with done_o.
`timescale 1ns / 1ps
module spectrum_sweep_max_hold_binner #(
  parameter int NUM_BINS = ssmhb_pkg::NUM_BINS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     mode_i,
  input  logic [31:0]                    frequency_i,
  input  logic [15:0]                    signal_level_i,
  input  logic [7:0]                     noise_level_i,
  input  logic [7:0]                     glitch_level_i,
  input  logic [ssmhb_pkg::IDX_W-1:0]    bin_index_i,
  output logic                           done_o,
  output logic [15:0]                    bin_signal_o,
  output logic [7:0]                     bin_noise_o,
  output logic [7:0]                     bin_glitch_o,
  output logic [7:0]                     filled_bins_o,
  output logic [15:0]                    auto_low_o,
  output logic [15:0]                    auto_high_o,
  output logic [31:0]                    peak_freq_out_o,
  output logic [15:0]                    peak_level_out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ssmhb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import ssmhb_pkg::*;

  localparam int AW = $clog2(NUM_BINS);
  localparam int CW = $clog2(NUM_BINS + 1);
  localparam int LW = DIV_LW;
  localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS - 1);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_MAP    = 15'b000000000000010,
    S_LOAD   = 15'b000000000000100,
    S_DIV    = 15'b000000000001000,
    S_SPAN   = 15'b000000000010000,
    S_WRD    = 15'b000000000100000,
    S_WUPD   = 15'b000000001000000,
    S_SCAN   = 15'b000000010000000,
    S_SCEND  = 15'b000000100000000,
    S_LVL    = 15'b000001000000000,
    S_AUTO   = 15'b000010000000000,
    S_FIN    = 15'b000100000000000,
    S_RES_RD = 15'b001000000000000,
    S_RES    = 15'b010000000000000,
    S_SPARE  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [31:0] band_start_q, band_start_d, band_end_q, band_end_d;
  logic [31:0] freq_step_q, freq_step_d;
  logic [15:0] min_span_q, min_span_d;
  logic [7:0]  disp_h_q, disp_h_d;

  // item
  logic [1:0]       mode_q, mode_d;
  logic [31:0]      freq_q, freq_d;
  logic [15:0]      rssi_q, rssi_d;
  logic [7:0]       noise_q, noise_d, glitch_q, glitch_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  // history state
  logic [NUM_BINS-1:0] valid_q, valid_d, visited_q, visited_d;
  logic [CW-1:0]       filled_q, filled_d;
  logic [AW-1:0]       prev_q, prev_d;
  logic [31:0]         sw_pk_f_q, sw_pk_f_d, sh_pk_f_q, sh_pk_f_d;
  logic [15:0]         sw_pk_l_q, sw_pk_l_d, sh_pk_l_q, sh_pk_l_d;
  logic [15:0]         lvl_lo_q, lvl_lo_d, lvl_hi_q, lvl_hi_d;

  // sequencer work registers
  logic [32:0]   map_f_q, map_f_d, nf_q, nf_d;
  logic          last_q, last_d;
  div_kind_e     kind_q, kind_d;
  logic [40:0]   num_q, num_d;
  logic [AW-1:0] xc_q, xc_d, xn_q, xn_d, wi_q, wi_d, hi_q, hi_d;
  logic [15:0]   mn_q, mn_d, mx_q, mx_d, span_q, span_d;
  logic          first_q, first_d, pend_q, pend_d;

  // shared divider
  logic [31:0]   rem_q, rem_d, dvs_q, dvs_d;
  logic [LW-1:0] quo_q, quo_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [32:0]   trial;
  logic          ge;
  logic [31:0]   rem_n;
  logic [LW-1:0] quo_n;

  // bin RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;
  logic          rd_chk, rd_ok_q;
  logic [15:0]   rd_sig;

  // address of the requested bin, and whether it exists
  logic [AW+IDX_W-1:0] idx_ext;
  logic [AW-1:0]       idx_addr;
  logic                idx_ok;

  // span arithmetic
  logic [AW:0]   sum_p, sum_n, lo_t, hi_t;
  logic [AW-1:0] lo_c, hi_c;
  logic [CW-1:0] fill_cand;
  logic [16:0]   dbl_span;
  logic [15:0]   margin, vmin, span_t, ms;
  logic [AW-1:0] bin_res;
  logic          map_done;

  assign idx_ext  = {{AW{1'b0}}, idx_q};
  assign idx_addr = idx_ext[AW-1:0];
  assign idx_ok   = (int'(idx_q) < NUM_BINS);

  assign trial = {rem_q, quo_q[LW-1]};
  assign ge    = (trial >= {1'b0, dvs_q});
  assign rem_n = ge ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
  assign quo_n = {quo_q[LW-2:0], ge};

  assign rd_sig = rd_ok_q ? ram_rdata[31:16] : 16'd0;

  ssmhb_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_bins (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign done_o      = (state_q == S_RES);

  assign bin_signal_o     = rd_sig;
  assign bin_noise_o      = rd_ok_q ? ram_rdata[15:8] : 8'd0;
  assign bin_glitch_o     = rd_ok_q ? ram_rdata[7:0] : 8'd0;
  assign filled_bins_o    = 8'(filled_q);
  assign auto_low_o       = lvl_lo_q;
  assign auto_high_o      = lvl_hi_q;
  assign peak_freq_out_o  = (sh_pk_f_q != 32'd0) ? sh_pk_f_q : sw_pk_f_q;
  assign peak_level_out_o = (sh_pk_l_q != 16'd0) ? sh_pk_l_q : sw_pk_l_q;

  always_comb begin
    state_d = state_q;
    band_start_d = band_start_q; band_end_d = band_end_q; freq_step_d = freq_step_q;
    min_span_d = min_span_q; disp_h_d = disp_h_q;
    mode_d = mode_q; freq_d = freq_q; rssi_d = rssi_q; noise_d = noise_q;
    glitch_d = glitch_q; idx_d = idx_q;
    valid_d = valid_q; visited_d = visited_q; filled_d = filled_q; prev_d = prev_q;
    sw_pk_f_d = sw_pk_f_q; sw_pk_l_d = sw_pk_l_q;
    sh_pk_f_d = sh_pk_f_q; sh_pk_l_d = sh_pk_l_q;
    lvl_lo_d = lvl_lo_q; lvl_hi_d = lvl_hi_q;
    map_f_d = map_f_q; nf_d = nf_q; last_d = last_q; kind_d = kind_q; num_d = num_q;
    xc_d = xc_q; xn_d = xn_q; wi_d = wi_q; hi_d = hi_q;
    mn_d = mn_q; mx_d = mx_q; span_d = span_q; first_d = first_q; pend_d = pend_q;
    rem_d = rem_q; dvs_d = dvs_q; quo_d = quo_q; cnt_d = cnt_q;
    ram_we = 1'b0; ram_waddr = wi_q;
    ram_wdata = {rssi_q, noise_q, glitch_q};
    ram_raddr = wi_q; rd_chk = 1'b1;
    bin_res = '0; map_done = 1'b0;
    sum_p = '0; sum_n = '0; lo_t = '0; hi_t = '0; lo_c = '0; hi_c = '0;
    fill_cand = '0; dbl_span = '0; margin = '0; vmin = '0; span_t = '0; ms = '0;

    // configuration writes land only while idle
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_BAND_START: band_start_d = cfg_data_i;
        REG_BAND_END:   band_end_d   = cfg_data_i;
        REG_FREQ_STEP:  freq_step_d  = cfg_data_i;
        REG_MIN_SPAN:   min_span_d   = cfg_data_i[15:0];
        REG_DISP_H:     disp_h_d     = cfg_data_i[7:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          mode_d = mode_i; freq_d = frequency_i; rssi_d = signal_level_i;
          noise_d = noise_level_i; glitch_d = glitch_level_i; idx_d = bin_index_i;
          unique case (mode_e'(mode_i))
            MODE_ADD: begin
              map_f_d = {1'b0, frequency_i};
              nf_d    = {1'b0, frequency_i} + {1'b0, freq_step_q};
              last_d  = (({1'b0, frequency_i} + {1'b0, freq_step_q}) >=
                         {1'b0, band_end_q});
              kind_d  = DK_XC;
              state_d = S_MAP;
            end
            MODE_BEGIN: begin
              wi_d = '0; pend_d = 1'b0; first_d = 1'b1;
              state_d = (filled_q >= CW'(2)) ? S_SCAN : S_FIN;
            end
            MODE_CLEAR: begin
              valid_d = '0; visited_d = '0; filled_d = '0;
              state_d = S_RES_RD;
            end
            MODE_READ: state_d = S_RES_RD;
            default: state_d = S_RES_RD;
          endcase
        end
      end
      S_MAP: begin
        // edge cases settle at once; the rest goes through the divider
        if (map_f_q <= {1'b0, band_start_q}) begin
          bin_res = '0; map_done = 1'b1;
        end else if (map_f_q >= {1'b0, band_end_q}) begin
          bin_res = LAST_BIN; map_done = 1'b1;
        end else begin
          num_d = 41'(32'(map_f_q - {1'b0, band_start_q})) * 41'(NUM_BINS - 1)
                + 41'((band_end_q - band_start_q) >> 1);
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        rem_d = 32'(num_q >> AW);
        quo_d = {num_q[AW-1:0], {(LW-AW){1'b0}}};
        dvs_d = band_end_q - band_start_q;
        cnt_d = 5'(AW);
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = rem_n; quo_d = quo_n; cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          if (kind_q == DK_MARGIN) begin
            state_d = S_AUTO;
          end else begin
            bin_res = quo_n[AW-1:0]; map_done = 1'b1;
          end
        end
      end
      S_SPAN: begin
        sum_p = {1'b0, prev_q} + {1'b0, xc_q};
        lo_t  = (xc_q == '0) ? '0 : (sum_p >> 1) + (AW+1)'(1);
        lo_c  = (lo_t > {1'b0, xc_q}) ? xc_q : lo_t[AW-1:0];
        sum_n = {1'b0, xc_q} + {1'b0, xn_q};
        hi_t  = last_q ? {1'b0, LAST_BIN} : (sum_n >> 1);
        hi_c  = (hi_t < {1'b0, xc_q}) ? xc_q : hi_t[AW-1:0];
        fill_cand = CW'(hi_c) + CW'(1);
        if (fill_cand > filled_q) filled_d = fill_cand;
        prev_d = xc_q;
        if (rssi_q > sw_pk_l_q) begin
          sw_pk_l_d = rssi_q; sw_pk_f_d = freq_q;
        end
        wi_d = lo_c; hi_d = hi_c;
        state_d = S_WRD;
      end
      S_WRD: begin
        ram_raddr = wi_q;
        state_d = S_WUPD;
      end
      S_WUPD: begin
        // first touch this sweep always stores; later ones keep the maximum
        if (!visited_q[wi_q] || (rssi_q > rd_sig)) begin
          ram_we = 1'b1;
          valid_d[wi_q] = 1'b1;
          visited_d[wi_q] = 1'b1;
        end
        if (wi_q == hi_q) begin
          state_d = S_RES_RD;
        end else begin
          wi_d = wi_q + AW'(1);
          state_d = S_WRD;
        end
      end
      S_SCAN: begin
        // issue one read a cycle, fold the bin read in the cycle before
        ram_raddr = wi_q;
        if (pend_q) begin
          first_d = 1'b0;
          mn_d = (first_q || rd_sig < mn_q) ? rd_sig : mn_q;
          mx_d = (first_q || rd_sig > mx_q) ? rd_sig : mx_q;
        end
        pend_d = 1'b1;
        wi_d = wi_q + AW'(1);
        if (wi_q == AW'(filled_q - CW'(1))) state_d = S_SCEND;
      end
      S_SCEND: begin
        mn_d = (rd_sig < mn_q) ? rd_sig : mn_q;
        mx_d = (rd_sig > mx_q) ? rd_sig : mx_q;
        state_d = S_LVL;
      end
      S_LVL: begin
        ms = (min_span_q == 16'd0) ? 16'd1 : min_span_q;
        span_t = mx_q - mn_q;
        if (span_t < ms) span_t = ms;
        span_d = span_t;
        dbl_span = MARGIN_PX * {1'b0, span_t};
        rem_d = '0;
        quo_d = dbl_span;
        dvs_d = {24'd0, (disp_h_q == 8'd0) ? 8'd1 : disp_h_q};
        cnt_d = 5'(LW);
        kind_d = DK_MARGIN;
        state_d = S_DIV;
      end
      S_AUTO: begin
        margin = quo_q[15:0];
        vmin = (mn_q > margin) ? (mn_q - margin) : 16'd0;
        lvl_lo_d = vmin;
        lvl_hi_d = vmin + span_q;
        state_d = S_FIN;
      end
      S_FIN: begin
        prev_d = '0;
        sh_pk_f_d = sw_pk_f_q; sh_pk_l_d = sw_pk_l_q;
        sw_pk_f_d = '0; sw_pk_l_d = '0;
        visited_d = '0;
        state_d = S_RES_RD;
      end
      S_RES_RD: begin
        ram_raddr = idx_addr;
        rd_chk = idx_ok;
        state_d = S_RES;
      end
      S_RES: state_d = S_IDLE;
      S_SPARE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase

    // route a finished bin mapping
    if (map_done) begin
      if (kind_q == DK_XC) begin
        xc_d = bin_res;
        if (last_q) begin
          state_d = S_SPAN;
        end else begin
          map_f_d = nf_q; kind_d = DK_XN; state_d = S_MAP;
        end
      end else begin
        xn_d = bin_res;
        state_d = S_SPAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      band_start_q <= '0; band_end_q <= '0; freq_step_q <= FREQ_STEP_RST;
      min_span_q <= MIN_SPAN_RST; disp_h_q <= DISP_H_RST;
      valid_q <= '0; visited_q <= '0; filled_q <= '0; prev_q <= '0;
      sw_pk_f_q <= '0; sw_pk_l_q <= '0; sh_pk_f_q <= '0; sh_pk_l_q <= '0;
      lvl_lo_q <= LEVEL_LOW_RST; lvl_hi_q <= LEVEL_HIGH_RST;
      kind_q <= DK_XC; cnt_q <= '0; first_q <= 1'b0; pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      band_start_q <= band_start_d; band_end_q <= band_end_d;
      freq_step_q <= freq_step_d; min_span_q <= min_span_d; disp_h_q <= disp_h_d;
      valid_q <= valid_d; visited_q <= visited_d; filled_q <= filled_d; prev_q <= prev_d;
      sw_pk_f_q <= sw_pk_f_d; sw_pk_l_q <= sw_pk_l_d;
      sh_pk_f_q <= sh_pk_f_d; sh_pk_l_q <= sh_pk_l_d;
      lvl_lo_q <= lvl_lo_d; lvl_hi_q <= lvl_hi_d;
      kind_q <= kind_d; cnt_q <= cnt_d; first_q <= first_d; pend_q <= pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mode_q <= mode_d; freq_q <= freq_d; rssi_q <= rssi_d; noise_q <= noise_d;
    glitch_q <= glitch_d; idx_q <= idx_d;
    map_f_q <= map_f_d; nf_q <= nf_d; last_q <= last_d; num_q <= num_d;
    xc_q <= xc_d; xn_q <= xn_d; wi_q <= wi_d; hi_q <= hi_d;
    mn_q <= mn_d; mx_q <= mx_d; span_q <= span_d;
    rem_q <= rem_d; dvs_q <= dvs_d; quo_q <= quo_d;
    rd_ok_q <= valid_q[ram_raddr] && rd_chk;
  end

`ifndef ASSERT_OFF
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe outside an item");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("item gave more than one result");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted item did not start");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(filled_q) <= NUM_BINS) else $error("fill count beyond bin count");
`endif

endmodule

// ===== verif/spectrum_sweep_max_hold_binner_tb.sv =====
// Self-checking testbench for the spectrum sweep max-hold binner.
// Depends on ssmhb_pkg and the spectrum_sweep_max_hold_binner RTL.
`timescale 1ns / 1ps
module spectrum_sweep_max_hold_binner_tb;
  import ssmhb_pkg::*;

  localparam int NB = NUM_BINS_DEF;
  // Slowest item is an add covering every bin.
  // The limit allows for sender gaps, begin-sweep scans and drains.
  localparam int LIMIT = 4_000_000;
  localparam int TARGET = 1950;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] freq;
    logic [15:0] rssi;
    logic [7:0]  noise;
    logic [7:0]  glitch;
    logic [6:0]  idx;
  } sweep_cmd_t;

  typedef struct packed {
    logic [15:0] sig;
    logic [7:0]  noise;
    logic [7:0]  glitch;
    logic [7:0]  filled;
    logic [15:0] lvl_lo;
    logic [15:0] lvl_hi;
    logic [31:0] pk_freq;
    logic [15:0] pk_level;
  } bin_readout_t;

  typedef struct packed {
    sweep_cmd_t   cmd;
    logic         fixed;
    bin_readout_t want;
  } table_row_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           mode_i = '0;
  logic [31:0]          frequency_i = '0;
  logic [15:0]          signal_level_i = '0;
  logic [7:0]           noise_level_i = '0;
  logic [7:0]           glitch_level_i = '0;
  logic [IDX_W-1:0]     bin_index_i = '0;
  logic                 done_o;
  logic [15:0]          bin_signal_o;
  logic [7:0]           bin_noise_o;
  logic [7:0]           bin_glitch_o;
  logic [7:0]           filled_bins_o;
  logic [15:0]          auto_low_o;
  logic [15:0]          auto_high_o;
  logic [31:0]          peak_freq_out_o;
  logic [15:0]          peak_level_out_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i = '0;

  spectrum_sweep_max_hold_binner u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Shadow copy of the registers, as last written.
  logic [31:0] band_lo_q = '0, band_hi_q = '0, step_q = FREQ_STEP_RST;
  logic [15:0] min_span_q = MIN_SPAN_RST;
  logic [7:0]  disp_h_q = DISP_H_RST;

  // Shadow copy of the bin history and the sweep bookkeeping.
  logic [15:0]  hold_sig [NB];
  logic [7:0]   hold_noise [NB];
  logic [7:0]   hold_glitch [NB];
  bit           hold_seen [NB];
  int unsigned  fill_cnt, last_bin;
  logic [31:0]  sweep_pk_f, shown_pk_f;
  logic [15:0]  sweep_pk_lv, shown_pk_lv, lvl_lo, lvl_hi;

  bin_readout_t pending_readouts [$];
  int unsigned  errors = 0;
  int unsigned  accepted = 0;
  int unsigned  cycles = 0;
  bit           tx_gaps = 1'b1;

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic check_field(string what, longint unsigned got, longint unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  function automatic int unsigned freq_bin(longint unsigned f);
    longint unsigned span, delta;
    if (f <= longint'(band_lo_q)) return 0;
    if (f >= longint'(band_hi_q)) return NB - 1;
    span  = longint'(band_hi_q) - longint'(band_lo_q);
    delta = f - longint'(band_lo_q);
    return int'((delta * (NB - 1) + span / 2) / span);
  endfunction

  function automatic void wipe_history();
    fill_cnt = 0;
    for (int i = 0; i < NB; i++) begin
      hold_sig[i] = '0;
      hold_noise[i] = '0;
      hold_glitch[i] = '0;
      hold_seen[i] = 1'b0;
    end
  endfunction

  function automatic void refresh_levels();
    int unsigned n, lo, hi, span, ms, h, margin, vmin;
    n = (fill_cnt > NB) ? NB : fill_cnt;
    if (n < 2) return;
    lo = hold_sig[0];
    hi = lo;
    for (int i = 1; i < n; i++) begin
      if (hold_sig[i] < lo) lo = hold_sig[i];
      if (hold_sig[i] > hi) hi = hold_sig[i];
    end
    span = hi - lo;
    ms = (min_span_q == 0) ? 1 : min_span_q;
    if (span < ms) span = ms;
    h = (disp_h_q == 0) ? 1 : disp_h_q;
    margin = ((2 * span) / h) & 32'hFFFF;
    vmin = (lo > margin) ? lo - margin : 0;
    lvl_lo = vmin[15:0];
    lvl_hi = 16'(vmin + span);
  endfunction

  function automatic void add_measurement(sweep_cmd_t c);
    longint unsigned nxt;
    bit          ends_sweep;
    int unsigned xc, lo, hi;
    nxt = longint'(c.freq) + longint'(step_q);
    ends_sweep = nxt >= longint'(band_hi_q);
    xc = freq_bin(c.freq);
    lo = (xc == 0) ? 0 : (last_bin + xc) / 2 + 1;
    hi = ends_sweep ? NB - 1 : (xc + freq_bin(nxt)) / 2;
    if (lo > xc) lo = xc;
    if (hi < xc) hi = xc;
    if (hi > NB - 1) hi = NB - 1;
    // First write in a sweep always lands; later ones only when strictly louder.
    for (int i = lo; i <= hi; i++) begin
      if (!hold_seen[i] || c.rssi > hold_sig[i]) begin
        hold_sig[i] = c.rssi;
        hold_noise[i] = c.noise;
        hold_glitch[i] = c.glitch;
        hold_seen[i] = 1'b1;
      end
    end
    if (hi + 1 > fill_cnt) fill_cnt = hi + 1;
    last_bin = xc;
    if (c.rssi > sweep_pk_lv) begin
      sweep_pk_lv = c.rssi;
      sweep_pk_f = c.freq;
    end
  endfunction

  function automatic bin_readout_t predict_readout(sweep_cmd_t c);
    bin_readout_t r;
    case (c.mode)
      MODE_ADD: add_measurement(c);
      MODE_BEGIN: begin
        refresh_levels();
        last_bin = 0;
        shown_pk_f = sweep_pk_f;
        shown_pk_lv = sweep_pk_lv;
        sweep_pk_f = '0;
        sweep_pk_lv = '0;
        for (int i = 0; i < NB; i++) hold_seen[i] = 1'b0;
      end
      MODE_CLEAR: wipe_history();
      default: ;
    endcase
    r.sig = hold_sig[c.idx];
    r.noise = hold_noise[c.idx];
    r.glitch = hold_glitch[c.idx];
    r.filled = fill_cnt[7:0];
    r.lvl_lo = lvl_lo;
    r.lvl_hi = lvl_hi;
    r.pk_freq = (shown_pk_f != 0) ? shown_pk_f : sweep_pk_f;
    r.pk_level = (shown_pk_lv != 0) ? shown_pk_lv : sweep_pk_lv;
    return r;
  endfunction

  // Wait until the binner has answered every item and then settle a little.
  task automatic drain();
    while (pending_readouts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Offer one item, hold it until taken, then predict and maybe idle.
  task automatic issue_cmd(sweep_cmd_t c, logic fixed, bin_readout_t want);
    bin_readout_t pred;
    int unsigned  r, gap;
    start          <= 1'b1;
    mode_i         <= c.mode;
    frequency_i    <= c.freq;
    signal_level_i <= c.rssi;
    noise_level_i  <= c.noise;
    glitch_level_i <= c.glitch;
    bin_index_i    <= c.idx;
    do @(posedge clk_i); while (busy);
    accepted++;
    pred = predict_readout(c);
    pending_readouts.push_back(fixed ? want : pred);
    if (!tx_gaps) return;
    r = $urandom_range(0, 99);
    gap = (r < 65) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 70);
    if ($urandom_range(0, 80) == 0) begin
      start <= 1'b0;
      drain();
    end else if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_BAND_START: band_lo_q = data;
      REG_BAND_END:   band_hi_q = data;
      REG_FREQ_STEP:  step_q = data;
      REG_MIN_SPAN:   min_span_q = data[15:0];
      default:        disp_h_q = data[7:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_band(logic [31:0] bs, logic [31:0] be, logic [31:0] st,
                           logic [15:0] ms, logic [7:0] dh);
    start <= 1'b0;
    drain();
    write_reg(REG_BAND_START, bs);
    write_reg(REG_BAND_END, be);
    write_reg(REG_FREQ_STEP, st);
    write_reg(REG_MIN_SPAN, {16'h0, ms});
    write_reg(REG_DISP_H, {24'h0, dh});
  endtask

  function automatic sweep_cmd_t rand_cmd(mode_e m, logic [31:0] f);
    sweep_cmd_t c;
    c.mode = m;
    c.freq = f;
    // Half the levels sit in a narrow band so that ties and near-ties occur.
    c.rssi = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                   : 16'($urandom_range(100, 103));
    c.noise = 8'($urandom_range(0, 255));
    c.glitch = 8'($urandom_range(0, 255));
    c.idx = 7'($urandom_range(0, NB - 1));
    return c;
  endfunction

  // One well-formed sweep: begin, then walk the band by the step.
  task automatic run_sweep(int unsigned stop_at);
    longint unsigned f;
    int unsigned     k;
    issue_cmd(rand_cmd(MODE_BEGIN, '0), 1'b0, '0);
    f = band_lo_q;
    k = 0;
    while (f <= longint'(band_hi_q) && k < 150 && accepted < stop_at) begin
      issue_cmd(rand_cmd(MODE_ADD, f[31:0]), 1'b0, '0);
      f += step_q;
      k++;
    end
  endtask

  table_row_t dir_tab [17];

  initial begin
    logic [31:0] bs, be, st;
    int unsigned stop_at, r;
    sweep_cmd_t  c;

    wipe_history();
    last_bin = 0;
    sweep_pk_f = '0; shown_pk_f = '0;
    sweep_pk_lv = '0; shown_pk_lv = '0;
    lvl_lo = LEVEL_LOW_RST;
    lvl_hi = LEVEL_HIGH_RST;

    // Directed rows run with the reset band (start = end = 0): every add is last.
    dir_tab[0]  = '{'{MODE_READ, 32'h0, 16'h0, 8'h0, 8'h0, 7'd0}, 1'b1,
                    '{16'h0, 8'h0, 8'h0, 8'd0, 16'd30, 16'd200, 32'h0, 16'h0}};
    dir_tab[1]  = '{'{MODE_ADD, 32'h0, 16'hFFFF, 8'hFF, 8'hFF, 7'd127}, 1'b1,
                    '{16'hFFFF, 8'hFF, 8'hFF, 8'd128, 16'd30, 16'd200, 32'h0, 16'hFFFF}};
    dir_tab[2]  = '{'{MODE_ADD, 32'hFFFF_FFFF, 16'h0, 8'h0, 8'h0, 7'd127}, 1'b0, '0};
    dir_tab[3]  = '{'{MODE_BEGIN, 32'h0, 16'h0, 8'h0, 8'h0, 7'd0}, 1'b0, '0};
    dir_tab[4]  = '{'{MODE_ADD, 32'h1, 16'h0, 8'h55, 8'hAA, 7'd64}, 1'b0, '0};
    dir_tab[5]  = '{'{MODE_BEGIN, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, 7'd63}, 1'b0, '0};
    dir_tab[6]  = '{'{MODE_CLEAR, 32'h0, 16'h0, 8'h0, 8'h0, 7'd64}, 1'b0, '0};
    dir_tab[7]  = '{'{MODE_BEGIN, 32'h0, 16'h0, 8'h0, 8'h0, 7'd1}, 1'b0, '0};
    dir_tab[8]  = '{'{MODE_ADD, 32'h0, 16'd5, 8'h1, 8'h2, 7'd3}, 1'b0, '0};
    dir_tab[9]  = '{'{MODE_BEGIN, 32'h0, 16'h0, 8'h0, 8'h0, 7'd3}, 1'b0, '0};
    dir_tab[10] = '{'{MODE_READ, 32'h1234_5678, 16'h1, 8'h1, 8'h1, 7'd127}, 1'b0, '0};
    dir_tab[11] = '{'{MODE_CLEAR, 32'h0, 16'h0, 8'h0, 8'h0, 7'd0}, 1'b0, '0};
    dir_tab[12] = '{'{MODE_ADD, 32'hFFFF_FFFF, 16'd100, 8'h7, 8'h9, 7'd127}, 1'b0, '0};
    dir_tab[13] = '{'{MODE_BEGIN, 32'h0, 16'h0, 8'h0, 8'h0, 7'd64}, 1'b0, '0};
    // Equal rssi later in the sweep must not overwrite; a louder one must.
    dir_tab[14] = '{'{MODE_ADD, 32'h0, 16'd7, 8'h1, 8'h1, 7'd10}, 1'b0, '0};
    dir_tab[15] = '{'{MODE_ADD, 32'h0, 16'd7, 8'h2, 8'h2, 7'd10}, 1'b0, '0};
    dir_tab[16] = '{'{MODE_ADD, 32'h0, 16'd8, 8'h3, 8'h3, 7'd10}, 1'b0, '0};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) issue_cmd(dir_tab[i].cmd, dir_tab[i].fixed, dir_tab[i].want);

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: load_band(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF / 40, 16'hFFFF, 8'd1);
        1: load_band(32'd1000, 32'd1000 + 127 * 100, 32'd100, 16'd1, 8'd255);
        2: load_band(32'd5000, 32'd5000, 32'd1, 16'd0, 8'd0);
        3: load_band(32'hFFFF_FF00, 32'hFFFF_FFFF, 32'd3, 16'd200, 8'd44);
        4: load_band(32'd0, 32'd300, 32'hFFFF_FFFF, 16'd40, 8'd2);
        5: load_band(32'd9000, 32'd100, 32'd50, 16'($urandom), 8'($urandom));
        default: begin
          bs = $urandom;
          be = bs + $urandom_range(1, 1 << 20);
          if (be < bs) be = 32'hFFFF_FFFF;
          st = (be - bs) / $urandom_range(2, 120) + 1;
          load_band(bs, be, st, 16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)));
        end
      endcase
      tx_gaps = (p % 3) != 1;
      stop_at = (p == 8) ? TARGET + 17 : 17 + (p + 1) * (TARGET / 9);
      while (accepted < stop_at) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          run_sweep(stop_at);
        end else begin
          // Noise: any mode at any frequency, clears kept rare.
          c = rand_cmd(mode_e'($urandom_range(0, 3)), $urandom);
          if (c.mode == MODE_CLEAR && $urandom_range(0, 3) != 0) c.mode = MODE_READ;
          issue_cmd(c, 1'b0, '0);
        end
      end
    end

    start <= 1'b0;
    drain();
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Take each strobed result and check it against the oldest prediction.
  always @(posedge clk_i) begin
    bin_readout_t w;
    if (rst_ni && done_o) begin
      if (pending_readouts.size() == 0) begin
        report_mismatch("unexpected result", bin_signal_o, 0);
      end else begin
        w = pending_readouts.pop_front();
        check_field("bin_signal", bin_signal_o, w.sig);
        check_field("bin_noise", bin_noise_o, w.noise);
        check_field("bin_glitch", bin_glitch_o, w.glitch);
        check_field("filled_bins", filled_bins_o, w.filled);
        check_field("auto_low", auto_low_o, w.lvl_lo);
        check_field("auto_high", auto_high_o, w.lvl_hi);
        check_field("peak_freq_out", peak_freq_out_o, w.pk_freq);
        check_field("peak_level_out", peak_level_out_o, w.pk_level);
      end
    end
  end

  // Bound the run in case the binner hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout with %0d results outstanding", pending_readouts.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
